FILE: rtl/crc3h_pkg.sv
// Shared types, constants and CRC byte fold for the CRC-32 string hash.
`default_nettype none
package crc3h_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 2;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
    localparam logic [BYTE_W-1:0] HASH_MARK = 8'h23;
    localparam logic [CNT_W-1:0]  HELD_NONE = 2'd0;
    localparam logic [CNT_W-1:0]  HELD_ONE  = 2'd1;
    localparam logic [CNT_W-1:0]  HELD_TWO  = 2'd2;

    typedef struct packed {
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [CNT_W-1:0]  count;
    } t_flush;

    function automatic logic [CRC_W-1:0] crc_table(input logic [BYTE_W-1:0] idx);
        logic [CRC_W-1:0] x;
        x = {{(CRC_W-BYTE_W){1'b0}}, idx};
        for (int k = 0; k < BYTE_W; k++) begin
            x = (x >> 1) ^ (x[0] ? CRC_POLY : '0);
        end
        return x;
    endfunction

    function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        return (crc >> BYTE_W) ^ crc_table(crc[BYTE_W-1:0] ^ b);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/crc32_hash_with_triple_hash_reset.sv
// Top level of the streaming CRC-32 string hash with triple-mark reset.
//
// Hashes one message byte per transfer with the reflected CRC-32 (0xEDB88320), starting
// from the inverted seed; a '#' followed by two more '#' restarts the CRC before it is
// folded. Two bytes are held back for that lookahead. A transfer with tlast flushes them
// and delivers the inverted CRC as one result via the input stage's hand-off register and
// the output register; an empty message gives the seed. One transfer is taken every cycle
// while the result side keeps up: the input stage folds at most one byte, the output stage
// folds the up to two held bytes. Writing the seed restarts the message in progress.
`default_nettype none
module crc32_hash_with_triple_hash_reset
    import crc3h_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CRC_W-1:0]  i_cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tuser,   // [0] has_byte
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [CRC_W-1:0]       m_axis_tdata    // [31:0] hash
);

    logic   fl_valid;
    logic   fl_take;
    t_flush fl;

    crc3h_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_has_byte    (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_fl_take     (fl_take),
        .o_fl_valid    (fl_valid),
        .o_fl          (fl)
    );

    crc3h_flush u_flush (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fl_valid (fl_valid),
        .i_fl       (fl),
        .o_fl_take  (fl_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_hash     (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: rtl/crc3h_front.sv
// Input stage: holds two bytes of lookahead, folds the oldest, hands off on last.
`default_nettype none
module crc3h_front
    import crc3h_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CRC_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data,
    input  wire logic              i_has_byte,
    input  wire logic              i_last,
    input  wire logic              i_fl_take,
    output logic                   o_fl_valid,
    output t_flush                 o_fl
);

    logic [CRC_W-1:0]  r_seed;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_b0, n_b0;
    logic [BYTE_W-1:0] r_b1, n_b1;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_fl_valid;
    t_flush            r_fl;
    logic              accept;
    logic [CRC_W-1:0]  fold_src;

    assign o_ready    = !r_fl_valid || i_fl_take;
    assign accept     = i_valid && o_ready;
    assign o_fl_valid = r_fl_valid;
    assign o_fl       = r_fl;

    always_comb begin
        n_crc    = r_crc;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_cnt    = r_cnt;
        fold_src = (r_b0 == HASH_MARK && r_b1 == HASH_MARK && i_data == HASH_MARK)
                   ? ~r_seed : r_crc;
        if (i_has_byte) begin
            case (r_cnt)
                HELD_NONE: begin
                    n_b0  = i_data;
                    n_cnt = HELD_ONE;
                end
                HELD_ONE: begin
                    n_b1  = i_data;
                    n_cnt = HELD_TWO;
                end
                default: begin
                    n_crc = fold_byte(fold_src, r_b0);
                    n_b0  = r_b1;
                    n_b1  = i_data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_crc      <= '1;
            r_b0       <= '0;
            r_b1       <= '0;
            r_cnt      <= HELD_NONE;
            r_fl_valid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
            r_crc  <= ~i_cfg_wr_data;
            r_b0   <= '0;
            r_b1   <= '0;
            r_cnt  <= HELD_NONE;
        end else begin
            if (accept && i_last) begin
                r_fl_valid <= 1'b1;
            end else if (i_fl_take) begin
                r_fl_valid <= 1'b0;
            end
            if (accept) begin
                if (i_last) begin
                    r_fl.crc   <= n_crc;
                    r_fl.b0    <= n_b0;
                    r_fl.b1    <= n_b1;
                    r_fl.count <= n_cnt;
                    r_crc      <= ~r_seed;
                    r_b0       <= '0;
                    r_b1       <= '0;
                    r_cnt      <= HELD_NONE;
                end else begin
                    r_crc <= n_crc;
                    r_b0  <= n_b0;
                    r_b1  <= n_b1;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/crc3h_flush.sv
// Output stage: folds the remaining held bytes and registers the inverted CRC.
`default_nettype none
module crc3h_flush
    import crc3h_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fl_valid,
    input  wire t_flush           i_fl,
    output logic                  o_fl_take,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [CRC_W-1:0]      o_hash
);

    logic             r_valid;
    logic [CRC_W-1:0] r_hash;
    logic [CRC_W-1:0] crc_a;
    logic [CRC_W-1:0] crc_b;

    assign o_fl_take = i_fl_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_hash    = r_hash;

    always_comb begin
        crc_a = (i_fl.count != HELD_NONE) ? fold_byte(i_fl.crc, i_fl.b0) : i_fl.crc;
        crc_b = (i_fl.count == HELD_TWO) ? fold_byte(crc_a, i_fl.b1) : crc_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fl_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fl_take) begin
            r_hash <= ~crc_b;
        end
    end

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the streaming CRC-32 string hash with triple-mark restart.
`timescale 1ns / 1ps
module tb
    import crc3h_pkg::*;
();

    localparam int CLK_PERIOD     = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 270;
    localparam int NUM_PHASES     = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              last;
    } t_msg_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [CRC_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;   // [7:0] data_byte
    logic              s_axis_tuser = 1'b0; // [0] has_byte
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CRC_W-1:0]  m_axis_tdata;        // [31:0] hash

    crc32_hash_with_triple_hash_reset u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_msg_item        pend_q[$];
    logic [CRC_W-1:0] hash_exp_q[$];

    logic [CRC_W-1:0]  hash_seed;
    logic [CRC_W-1:0]  crc_run;
    logic [BYTE_W-1:0] held[2];
    int                held_cnt;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  tx_gap_left = 0;
    int  rx_gap_left = 0;
    int  rx_long_left = 0;
    bit  long_stall_go = 1'b0;
    bit  long_stall_done = 1'b0;
    int  idle_cycles = 0;

    int  err_cnt = 0;
    int  items_sent = 0;
    int  msgs_sent = 0;
    int  msgs_aborted = 0;
    int  seed_writes = 0;
    int  hashes_checked = 0;
    int  mark_restarts = 0;

    function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            x = (x >> 1) ^ (x[0] ? CRC_POLY : '0);
        end
        return x;
    endfunction

    task automatic hash_restart();
        crc_run  = ~hash_seed;
        held[0]  = '0;
        held[1]  = '0;
        held_cnt = 0;
    endtask

    task automatic predict_hash(input t_msg_item it);
        if (it.has_byte) begin
            if (held_cnt == 2) begin
                if (held[0] == HASH_MARK && held[1] == HASH_MARK && it.data_byte == HASH_MARK)
                begin
                    crc_run = ~hash_seed;
                    mark_restarts++;
                end
                crc_run = crc_shift_byte(crc_run, held[0]);
                held[0] = held[1];
                held[1] = it.data_byte;
            end else begin
                held[held_cnt] = it.data_byte;
                held_cnt++;
            end
        end
        if (it.last) begin
            for (int k = 0; k < held_cnt; k++) begin
                crc_run = crc_shift_byte(crc_run, held[k]);
            end
            hash_exp_q = {hash_exp_q, ~crc_run};
            hash_restart();
        end
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] data, input logic has, input logic lst);
        t_msg_item it;
        it.data_byte = data;
        it.has_byte  = has;
        it.last      = lst;
        pend_q = {pend_q, it};
        if (has || lst) begin
            items_sent++;
        end
        if (lst) begin
            msgs_sent++;
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return HASH_MARK;
        end
        if (r < 44) begin
            return 8'h00;
        end
        if (r < 48) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Build one message; an incomplete one never gets tlast.
    task automatic queue_message(input bit complete);
        int len;
        bit last_on_byte;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (!complete && len == 0) begin
            len = 1;
        end
        last_on_byte = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            push_item(pick_byte(), 1'b1, complete && last_on_byte && k == len - 1);
        end
        if (complete && (len == 0 || !last_on_byte)) begin
            push_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || hash_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_seed(input logic [CRC_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hash_seed = value;
        hash_restart();
        seed_writes++;
    endtask

    always @(posedge i_clk) begin : drive_proc
        bit s_fire;
        s_fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_fire) begin
                predict_hash(pend_q.pop_front());
            end
            if (s_axis_tvalid && !s_fire) begin
                // hold the offered item until its transfer
            end else if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if ($urandom_range(0, 99) < tx_idle_pct) begin
                tx_gap_left = $urandom_range(0, 18);
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pend_q[0].data_byte;
                s_axis_tuser  <= pend_q[0].has_byte;
                s_axis_tlast  <= pend_q[0].last;
            end
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        logic [CRC_W-1:0] exp_hash;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                hashes_checked++;
                if (hash_exp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected hash: expected none, actual %08h",
                             $time, m_axis_tdata);
                end else begin
                    exp_hash = hash_exp_q.pop_front();
                    if (m_axis_tdata !== exp_hash) begin
                        err_cnt++;
                        $display("%0t: hash mismatch: expected %08h, actual %08h",
                                 $time, exp_hash, m_axis_tdata);
                    end
                end
            end
            if (long_stall_go && !long_stall_done) begin
                long_stall_done = 1'b1;
                rx_long_left = LONG_STALL - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_long_left > 0) begin
                rx_long_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap_left > 0) begin
                rx_gap_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap_left = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim_proc
        logic [CRC_W-1:0] seed_pick;
        int phase_target;
        hash_seed = '0;
        hash_restart();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 10;
        // empty message under the reset seed
        push_item(8'h00, 1'b0, 1'b1);
        for (int k = 0; k < 9; k++) begin
            push_item(8'h31 + BYTE_W'(k), 1'b1, k == 8);
        end
        push_item(8'hFF, 1'b1, 1'b1);
        // ignored item, then a run of four marks and a flush-only end
        push_item(8'hC3, 1'b0, 1'b0);
        repeat (4) push_item(HASH_MARK, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b1);
        // three marks ending the message: no restart in the flush
        push_item(HASH_MARK, 1'b1, 1'b0);
        push_item(HASH_MARK, 1'b1, 1'b0);
        push_item(HASH_MARK, 1'b1, 1'b1);
        // leave a message open, then abort it with a seed write
        push_item(HASH_MARK, 1'b1, 1'b0);
        push_item(8'h7E, 1'b1, 1'b0);
        msgs_aborted++;
        write_seed(32'hFFFF_FFFF);
        push_item(8'h5A, 1'b0, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: seed_pick = 32'h0000_0000;
                1: seed_pick = 32'hFFFF_FFFF;
                4: seed_pick = 32'h8000_0001;
                default: seed_pick = CRC_W'($urandom());
            endcase
            write_seed(seed_pick);
            case (p)
                0: begin tx_idle_pct = 20; rx_idle_pct = 20; end
                1: begin tx_idle_pct = 0;  rx_idle_pct = 30; end
                2: begin tx_idle_pct = 10; rx_idle_pct = 10; end
                3: begin tx_idle_pct = 40; rx_idle_pct = 0;  end
                4: begin tx_idle_pct = 5;  rx_idle_pct = 5;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (p == 2) begin
                long_stall_go = 1'b1;
            end
            phase_target = items_sent + PHASE_ITEMS;
            while (items_sent < phase_target) begin
                queue_message(1'b1);
            end
            if (p != NUM_PHASES - 1 && $urandom_range(0, 1) == 1) begin
                queue_message(1'b0);
                msgs_aborted++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hash_exp_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d hashes never arrived", $time, hash_exp_q.size());
        end
        $display("run covered %0d items in %0d messages, %0d left open, %0d seed writes",
                 items_sent, msgs_sent, msgs_aborted, seed_writes);
        $display("%0d hashes compared, %0d triple-mark restarts, %0d mismatches",
                 hashes_checked, mark_restarts, err_cnt);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
